@@ sv/cbfsp_pkg.sv @@
// Package: shared types, widths and codes of the best-fit slot packer.
package cbfsp_pkg;

    localparam int DEF_MAX_SLOTS = 128;
    localparam int LEN_BITS = 10;
    localparam int OUT_IDX_BITS = 7;
    localparam int SCOUNT_BITS = 8;
    localparam int CFG_ADDR_BITS = 1;
    localparam int CFG_DATA_BITS = 10;

    localparam logic [LEN_BITS-1:0] RST_CAPACITY = LEN_BITS'(32);
    localparam logic [SCOUNT_BITS-1:0] RST_SLOT_COUNT = SCOUNT_BITS'(128);

    localparam logic [CFG_ADDR_BITS-1:0] CFG_CAPACITY = 1'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_SLOT_COUNT = 1'd1;

    localparam logic ACT_PLACE = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        ST_PLACED   = 2'd0,
        ST_NO_ROOM  = 2'd1,
        ST_TOO_LONG = 2'd2,
        ST_CLEARED  = 2'd3
    } t_status;

    typedef struct packed {
        logic                action;
        logic [LEN_BITS-1:0] piece_length;
    } t_in_item;

    typedef struct packed {
        t_status                 status;
        logic [OUT_IDX_BITS-1:0] slot_index;
        logic [LEN_BITS-1:0]     rem_space;
    } t_out_item;

endpackage

@@ sv/cbfsp_list_mem.sv @@
// Partial-slot list memory: one shared address port for writes and registered reads.
module cbfsp_list_mem #(
    parameter int DEPTH = cbfsp_pkg::DEF_MAX_SLOTS,
    parameter int WIDTH = cbfsp_pkg::LEN_BITS + 7,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);
    import cbfsp_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/cbfsp_ctrl.sv @@
// Packer sequencer: list scan, best-fit choice, list update and fresh-slot counter.
module cbfsp_ctrl #(
    parameter int MAX_SLOTS = cbfsp_pkg::DEF_MAX_SLOTS,
    parameter int IW        = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
    parameter int CW        = $clog2(MAX_SLOTS + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_clear,
    input  logic [CW-1:0]                       i_slots,
    input  logic [cbfsp_pkg::LEN_BITS-1:0]      i_cap,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  cbfsp_pkg::t_in_item                 i_in_item,
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output cbfsp_pkg::t_out_item                o_res_item,
    output logic                                o_mem_we,
    output logic [IW-1:0]                       o_mem_addr,
    output logic [IW+cbfsp_pkg::LEN_BITS-1:0]   o_mem_wdata,
    input  logic [IW+cbfsp_pkg::LEN_BITS-1:0]   i_mem_rdata
);
    import cbfsp_pkg::*;

    localparam int EW = IW + LEN_BITS;
    localparam logic [CW-1:0] RST_FRESH =
        (int'(RST_SLOT_COUNT) > MAX_SLOTS) ? CW'(MAX_SLOTS) : CW'(RST_SLOT_COUNT);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_LAST   = 6'b000100,
        S_DECIDE = 6'b001000,
        S_APPEND = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_fresh, n_fresh;
    logic [CW-1:0]       r_pcount, n_pcount;
    logic [LEN_BITS-1:0] r_len, n_len;
    logic [IW-1:0]       r_idx, n_idx;
    logic                r_cmp_vld, n_cmp_vld;
    logic [IW-1:0]       r_cmp_pos, n_cmp_pos;
    logic                r_found, n_found;
    logic [IW-1:0]       r_best_pos, n_best_pos;
    logic [LEN_BITS-1:0] r_best_space, n_best_space;
    logic [IW-1:0]       r_best_id, n_best_id;
    logic [EW-1:0]       r_last, n_last;
    logic [IW-1:0]       r_slot, n_slot;
    logic [LEN_BITS-1:0] r_left, n_left;
    t_status             r_status, n_status;

    logic [CW-1:0]       w_pc_m1;
    logic [CW-1:0]       w_fresh_m1;
    logic [LEN_BITS-1:0] w_rd_space;
    logic [IW-1:0]       w_rd_id;
    logic [LEN_BITS-1:0] w_fresh_left;
    logic [OUT_IDX_BITS+IW-1:0] w_slot_ext;

    assign w_pc_m1      = r_pcount - 1'b1;
    assign w_fresh_m1   = r_fresh - 1'b1;
    assign w_rd_space   = i_mem_rdata[LEN_BITS-1:0];
    assign w_rd_id      = i_mem_rdata[EW-1:LEN_BITS];
    assign w_fresh_left = i_cap - r_len;
    assign w_slot_ext   = {{OUT_IDX_BITS{1'b0}}, r_slot};

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res_item.status     = r_status;
    assign o_res_item.slot_index = w_slot_ext[OUT_IDX_BITS-1:0];
    assign o_res_item.rem_space  = r_left;

    always_comb begin
        n_state      = r_state;
        n_fresh      = r_fresh;
        n_pcount     = r_pcount;
        n_len        = r_len;
        n_idx        = r_idx;
        n_cmp_vld    = 1'b0;
        n_cmp_pos    = r_cmp_pos;
        n_found      = r_found;
        n_best_pos   = r_best_pos;
        n_best_space = r_best_space;
        n_best_id    = r_best_id;
        n_last       = r_last;
        n_slot       = r_slot;
        n_left       = r_left;
        n_status     = r_status;
        o_mem_we     = 1'b0;
        o_mem_addr   = r_idx;
        o_mem_wdata  = r_last;

        if (r_cmp_vld) begin
            if (w_rd_space >= r_len && (!r_found || w_rd_space < r_best_space)) begin
                n_found      = 1'b1;
                n_best_pos   = r_cmp_pos;
                n_best_space = w_rd_space;
                n_best_id    = w_rd_id;
            end
            if (CW'(r_cmp_pos) == w_pc_m1) begin
                n_last = i_mem_rdata;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_slot   = '0;
                    n_left   = '0;
                    n_found  = 1'b0;
                    n_idx    = '0;
                    n_len    = i_in_item.piece_length;
                    n_state  = S_DONE;
                    if (i_in_item.action == ACT_CLEAR) begin
                        n_fresh  = i_slots;
                        n_pcount = '0;
                        n_status = ST_CLEARED;
                    end else if (i_in_item.piece_length > i_cap) begin
                        n_status = ST_TOO_LONG;
                    end else if (i_in_item.piece_length == i_cap) begin
                        if (r_fresh != '0) begin
                            n_fresh  = w_fresh_m1;
                            n_slot   = w_fresh_m1[IW-1:0];
                            n_status = ST_PLACED;
                        end else begin
                            n_status = ST_NO_ROOM;
                        end
                    end else if (r_pcount != '0) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DECIDE;
                    end
                end
            end
            S_SCAN: begin
                n_cmp_vld = 1'b1;
                n_cmp_pos = r_idx;
                if (CW'(r_idx) == w_pc_m1) begin
                    n_state = S_LAST;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_LAST: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_state = S_DONE;
                if (r_found) begin
                    n_status    = ST_PLACED;
                    n_slot      = r_best_id;
                    n_left      = r_best_space - r_len;
                    o_mem_we    = 1'b1;
                    o_mem_addr  = r_best_pos;
                    o_mem_wdata = r_last;
                    if (n_left != '0) begin
                        n_state = S_APPEND;
                    end else begin
                        n_pcount = w_pc_m1;
                    end
                end else if (r_fresh != '0) begin
                    n_status = ST_PLACED;
                    n_fresh  = w_fresh_m1;
                    n_slot   = w_fresh_m1[IW-1:0];
                    n_left   = w_fresh_left;
                    if (32'(r_pcount) < 32'(MAX_SLOTS)) begin
                        o_mem_we    = 1'b1;
                        o_mem_addr  = r_pcount[IW-1:0];
                        o_mem_wdata = {w_fresh_m1[IW-1:0], w_fresh_left};
                        n_pcount    = r_pcount + 1'b1;
                    end
                end else begin
                    n_status = ST_NO_ROOM;
                end
            end
            S_APPEND: begin
                o_mem_we    = 1'b1;
                o_mem_addr  = w_pc_m1[IW-1:0];
                o_mem_wdata = {r_slot, r_left};
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_clear) begin
            n_fresh  = i_slots;
            n_pcount = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fresh   <= RST_FRESH;
            r_pcount  <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fresh   <= n_fresh;
            r_pcount  <= n_pcount;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len        <= n_len;
        r_idx        <= n_idx;
        r_cmp_pos    <= n_cmp_pos;
        r_found      <= n_found;
        r_best_pos   <= n_best_pos;
        r_best_space <= n_best_space;
        r_best_id    <= n_best_id;
        r_last       <= n_last;
        r_slot       <= n_slot;
        r_left       <= n_left;
        r_status     <= n_status;
    end

    a_cmp_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> (r_state == S_SCAN || r_state == S_LAST))
        else $error("compare valid outside the list scan");

    a_write_when_updating: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_we |-> (r_state == S_DECIDE || r_state == S_APPEND))
        else $error("list write outside the update states");

    a_last_to_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LAST) |=> (r_state == S_DECIDE))
        else $error("scan end not followed by the decision");

    a_place_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && i_in_item.action == ACT_PLACE
         && i_in_item.piece_length < i_cap && r_pcount != '0) |=> (r_state == S_SCAN))
        else $error("short piece with a non-empty list did not start a scan");

endmodule

@@ sv/chunk_best_fit_slot_packer_top.sv @@
// Top level of the best-fit slot packer: configuration registers, result register.
// Flow: batch clear, over-long and full-size pieces go from idle straight to the result;
// a shorter piece scans the partial list (skipped when the list is empty), then decides,
// with an extra update step when the chosen partial slot stays open.
// Throughput: one item at a time; the list scan reads one memory entry per cycle
// through the single list memory port.
// Reset: synchronous, active low; registers return to capacity 32 and slot count 128,
// all slots fresh and the partial list empty; the list memory itself is not cleared.
module chunk_best_fit_slot_packer_top #(
    parameter int MAX_SLOTS = cbfsp_pkg::DEF_MAX_SLOTS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [cbfsp_pkg::CFG_ADDR_BITS-1:0]    i_cfg_addr,
    input  logic [cbfsp_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  cbfsp_pkg::t_in_item                    i_in_item,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output cbfsp_pkg::t_out_item                   o_out_item
);
    import cbfsp_pkg::*;

    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int EW = IW + LEN_BITS;

    logic [LEN_BITS-1:0]    r_cap;
    logic [SCOUNT_BITS-1:0] r_scount;
    logic [SCOUNT_BITS-1:0] w_scount_next;
    logic [CW-1:0]          w_slots;
    logic                   w_clear;

    logic                   r_out_vld;
    t_out_item              r_out_item;

    logic                   w_res_valid;
    logic                   w_res_ready;
    t_out_item              w_res_item;
    logic                   w_mem_we;
    logic [IW-1:0]          w_mem_addr;
    logic [EW-1:0]          w_mem_wdata;
    logic [EW-1:0]          w_mem_rdata;

    assign w_clear = i_cfg_we && (i_cfg_addr == CFG_CAPACITY || i_cfg_addr == CFG_SLOT_COUNT);
    assign w_scount_next = (i_cfg_we && i_cfg_addr == CFG_SLOT_COUNT) ?
                           i_cfg_data[SCOUNT_BITS-1:0] : r_scount;
    assign w_slots = (32'(w_scount_next) > 32'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : CW'(w_scount_next);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= RST_CAPACITY;
            r_scount <= RST_SLOT_COUNT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_CAPACITY:   r_cap    <= i_cfg_data[LEN_BITS-1:0];
                CFG_SLOT_COUNT: r_scount <= i_cfg_data[SCOUNT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // hold a finished transfer until the sink takes it
    assign w_res_ready = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_res_ready) begin
            r_out_vld <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out_item <= w_res_item;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

    cbfsp_ctrl #(
        .MAX_SLOTS (MAX_SLOTS),
        .IW        (IW),
        .CW        (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (w_clear),
        .i_slots     (w_slots),
        .i_cap       (r_cap),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res_item  (w_res_item),
        .o_mem_we    (w_mem_we),
        .o_mem_addr  (w_mem_addr),
        .o_mem_wdata (w_mem_wdata),
        .i_mem_rdata (w_mem_rdata)
    );

    cbfsp_list_mem #(
        .DEPTH (MAX_SLOTS),
        .WIDTH (EW),
        .AW    (IW)
    ) u_list_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_addr  (w_mem_addr),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_mem_rdata)
    );

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the best-fit slot packer: directed and random placements.
`timescale 1ns / 100ps

module tb;
    import cbfsp_pkg::*;

    localparam int MAX_SLOTS = DEF_MAX_SLOTS;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 150;
    localparam int HOLD_CYCLES = 600;
    localparam int N_PHASES = 12;
    localparam int PHASE_ITEMS = 125;
    localparam int PRESSURE_PHASE = 4;

    class placement_checker;
        logic [LEN_BITS-1:0]     capacity;
        logic [SCOUNT_BITS-1:0]  slot_count;
        logic [OUT_IDX_BITS-1:0] fresh_stack[MAX_SLOTS];
        int                      fresh_n;
        logic [OUT_IDX_BITS-1:0] open_ids[MAX_SLOTS];
        logic [LEN_BITS-1:0]     open_space[MAX_SLOTS];
        int                      open_n;
        t_out_item               placements_due[$];
        int                      mismatches;
        int                      results_seen;
        int                      status_tally[4];

        function new();
            mismatches = 0;
            results_seen = 0;
            foreach (status_tally[i]) status_tally[i] = 0;
            capacity = RST_CAPACITY;
            slot_count = RST_SLOT_COUNT;
            start_batch();
        endfunction

        function void start_batch();
            int n;
            n = (int'(slot_count) > MAX_SLOTS) ? MAX_SLOTS : int'(slot_count);
            for (int i = 0; i < n; i++) fresh_stack[i] = OUT_IDX_BITS'(i);
            fresh_n = n;
            open_n = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_BITS-1:0] addr,
                                logic [CFG_DATA_BITS-1:0] data);
            case (addr)
                CFG_CAPACITY: begin
                    capacity = data[LEN_BITS-1:0];
                    start_batch();
                end
                CFG_SLOT_COUNT: begin
                    slot_count = data[SCOUNT_BITS-1:0];
                    start_batch();
                end
                default: ;
            endcase
        endfunction

        function void note_input(t_in_item it);
            t_out_item               r;
            int                      best;
            int                      room;
            int                      left;
            logic [OUT_IDX_BITS-1:0] slot;
            r.status = ST_PLACED;
            slot = '0;
            left = 0;
            best = -1;
            room = 0;
            if (it.action == ACT_CLEAR) begin
                start_batch();
                r.status = ST_CLEARED;
            end else if (it.piece_length > capacity) begin
                r.status = ST_TOO_LONG;
            end else if (it.piece_length == capacity) begin
                if (fresh_n == 0) begin
                    r.status = ST_NO_ROOM;
                end else begin
                    fresh_n--;
                    slot = fresh_stack[fresh_n];
                end
            end else begin
                for (int i = 0; i < open_n; i++) begin
                    if (open_space[i] >= it.piece_length && (best < 0 || open_space[i] < room)) begin
                        best = i;
                        room = int'(open_space[i]);
                    end
                end
                if (best >= 0) begin
                    slot = open_ids[best];
                    open_ids[best] = open_ids[open_n-1];
                    open_space[best] = open_space[open_n-1];
                    open_n--;
                end else if (fresh_n > 0) begin
                    fresh_n--;
                    slot = fresh_stack[fresh_n];
                    room = int'(capacity);
                end else begin
                    r.status = ST_NO_ROOM;
                end
                if (r.status == ST_PLACED) begin
                    left = room - int'(it.piece_length);
                    if (left > 0 && open_n < MAX_SLOTS) begin
                        open_ids[open_n] = slot;
                        open_space[open_n] = LEN_BITS'(left);
                        open_n++;
                    end
                end
            end
            if (r.status != ST_PLACED) begin
                slot = '0;
                left = 0;
            end
            r.slot_index = slot;
            r.rem_space = LEN_BITS'(left);
            placements_due = {placements_due, r};
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            results_seen++;
            if (placements_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with none due: status %0d slot %0d space %0d",
                             $time, got.status, got.slot_index, got.rem_space);
                return;
            end
            want = placements_due.pop_front();
            status_tally[want.status]++;
            if (got.status !== want.status || got.slot_index !== want.slot_index ||
                got.rem_space !== want.rem_space) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: expected status %0d slot %0d space %0d, got %0d %0d %0d",
                             $time, want.status, want.slot_index, want.rem_space,
                             got.status, got.slot_index, got.rem_space);
            end
        endfunction

        function int pending();
            return placements_due.size();
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_ADDR_BITS-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    t_in_item                 i_in_item = '0;
    logic                     i_out_ready = 1'b0;
    logic                     o_in_ready;
    logic                     o_out_valid;
    t_out_item                o_out_item;

    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    logic                pressure_req = 1'b0;
    int                  quiet_cycles = 0;
    int                  items_sent = 0;
    int                  settings_used = 1;
    logic [LEN_BITS-1:0] cur_cap = RST_CAPACITY;
    placement_checker    placements = new();

    int phase_cap[N_PHASES]   = '{32, 1, 1023, 100, 7, 2, 0, 640, 15, -1, 1023, 32};
    int phase_count[N_PHASES] = '{128, 5, 128, 16, 200, 1, 3, 128, 0, -1, 1, 1023};

    chunk_best_fit_slot_packer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) placements.write_reg(i_cfg_addr, i_cfg_data);
            if (i_in_valid && o_in_ready) placements.note_input(i_in_item);
            if (o_out_valid && i_out_ready) placements.check_result(o_out_item);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // hold off once for a long stretch so the block backs up into its input
    initial begin
        int   hold_left;
        logic pressure_done;
        hold_left = 0;
        pressure_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (pressure_req && !pressure_done) begin
                pressure_done = 1'b1;
                hold_left = HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    task automatic transfer_item(logic act, logic [LEN_BITS-1:0] len);
        t_in_item it;
        it.action = act;
        it.piece_length = len;
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
    endtask

    task automatic write_setting(logic [CFG_ADDR_BITS-1:0] addr, logic [CFG_DATA_BITS-1:0] data);
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (placements.pending() != 0) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (addr == CFG_CAPACITY) cur_cap = data[LEN_BITS-1:0];
    endtask

    function automatic t_in_item random_piece(logic [LEN_BITS-1:0] cap);
        t_in_item it;
        int       c;
        int       pick;
        c = int'(cap);
        it.action = ACT_PLACE;
        it.piece_length = LEN_BITS'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            it.action = ACT_CLEAR;
        end else if (pick < 8) begin
            it.action = ACT_PLACE;
        end else if (pick < 12) begin
            it.piece_length = '0;
        end else if (pick < 22) begin
            it.piece_length = cap;
        end else if (pick < 27) begin
            if (c < 1023) it.piece_length = LEN_BITS'($urandom_range(c + 1, 1023));
        end else if (pick < 50 && c >= 16) begin
            it.piece_length = LEN_BITS'($urandom_range(1, c / 8));
        end else if (c > 1) begin
            it.piece_length = LEN_BITS'($urandom_range(1, c - 1));
        end else begin
            it.piece_length = cap;
        end
        return it;
    endfunction

    initial begin
        int       cap_val;
        int       count_val;
        t_in_item it;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        transfer_item(ACT_PLACE, 10'd32);
        transfer_item(ACT_PLACE, 10'd33);
        transfer_item(ACT_PLACE, 10'd1023);
        transfer_item(ACT_PLACE, 10'd0);
        transfer_item(ACT_PLACE, 10'd10);
        transfer_item(ACT_PLACE, 10'd22);
        transfer_item(ACT_PLACE, 10'd22);
        transfer_item(ACT_PLACE, 10'd5);
        transfer_item(ACT_PLACE, 10'd16);
        transfer_item(ACT_PLACE, 10'd16);
        transfer_item(ACT_CLEAR, 10'd1023);

        write_setting(CFG_CAPACITY, 10'd0);
        write_setting(CFG_SLOT_COUNT, 10'd3);
        transfer_item(ACT_PLACE, 10'd0);
        transfer_item(ACT_PLACE, 10'd1);
        transfer_item(ACT_PLACE, 10'd0);
        transfer_item(ACT_PLACE, 10'd0);
        transfer_item(ACT_PLACE, 10'd0);

        write_setting(CFG_CAPACITY, 10'd1023);
        write_setting(CFG_SLOT_COUNT, 10'd1);
        transfer_item(ACT_PLACE, 10'd1023);
        transfer_item(ACT_PLACE, 10'd1023);
        transfer_item(ACT_CLEAR, 10'd0);
        transfer_item(ACT_PLACE, 10'd500);
        transfer_item(ACT_PLACE, 10'd1023);
        transfer_item(ACT_PLACE, 10'd600);
        transfer_item(ACT_PLACE, 10'd0);

        write_setting(CFG_SLOT_COUNT, 10'd0);
        transfer_item(ACT_PLACE, 10'd5);
        settings_used += 5;

        for (int p = 0; p < N_PHASES; p++) begin
            cap_val = (phase_cap[p] < 0) ? $urandom_range(1, 1023) : phase_cap[p];
            count_val = (phase_count[p] < 0) ? $urandom_range(1, MAX_SLOTS) : phase_count[p];
            write_setting(CFG_CAPACITY, CFG_DATA_BITS'(cap_val));
            write_setting(CFG_SLOT_COUNT, CFG_DATA_BITS'(count_val));
            settings_used++;
            case (p % 4)
                0: begin
                    send_idle_pct <= 0;
                    recv_stall_pct <= 0;
                end
                1: begin
                    send_idle_pct <= 45;
                    recv_stall_pct <= 0;
                end
                2: begin
                    send_idle_pct <= 0;
                    recv_stall_pct <= 45;
                end
                default: begin
                    send_idle_pct <= 37;
                    recv_stall_pct <= 37;
                end
            endcase
            if (p == PRESSURE_PHASE) pressure_req <= 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                it = random_piece(cur_cap);
                transfer_item(it.action, it.piece_length);
            end
        end

        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (placements.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d items across %0d register settings, %0d results checked",
                 items_sent, settings_used, placements.results_seen);
        $display("Outcomes: placed %0d, no room %0d, too long %0d, cleared %0d; mismatches %0d",
                 placements.status_tally[ST_PLACED], placements.status_tally[ST_NO_ROOM],
                 placements.status_tally[ST_TOO_LONG], placements.status_tally[ST_CLEARED],
                 placements.mismatches);
        if (placements.mismatches == 0 && placements.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/cbfsp_pkg.sv
sv/cbfsp_list_mem.sv
sv/cbfsp_ctrl.sv
sv/chunk_best_fit_slot_packer_top.sv
tb/sv/tb.sv
